// ===== design/ttv_pkg.sv =====
// Types and constants shared by the triangle tangent vector block.
`timescale 1ns / 1ps
package ttv_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int ACC_W       = 67;
    localparam int DELTA_W     = 33;
    localparam int MAG_BITS    = 15;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } vertex_t;

    typedef struct packed {
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic               last_of_triangle;
    } result_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] e1x;
        logic signed [DELTA_W-1:0] e1y;
        logic signed [DELTA_W-1:0] e1z;
        logic signed [DELTA_W-1:0] e2x;
        logic signed [DELTA_W-1:0] e2y;
        logic signed [DELTA_W-1:0] e2z;
        logic signed [DELTA_W-1:0] du1;
        logic signed [DELTA_W-1:0] dv1;
        logic signed [DELTA_W-1:0] du2;
        logic signed [DELTA_W-1:0] dv2;
    } tri_t;

    function automatic logic signed [DELTA_W-1:0] sdiff(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        sdiff = {a[31], a} - {b[31], b};
    endfunction

endpackage

// ===== design/ttv_fifo.sv =====
// Short queue of triangle records between the front and back ends.
`timescale 1ns / 1ps
module ttv_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ttv_pkg::tri_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output ttv_pkg::tri_t head
);
    import ttv_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tri_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/ttv_front.sv =====
// Front end: takes vertex words, holds the first two, forms edge and uv deltas.
`timescale 1ns / 1ps
module ttv_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ttv_pkg::vertex_t s_vertex,
    input  logic             q_full,
    output logic             q_push,
    output ttv_pkg::tri_t    q_data
);
    import ttv_pkg::*;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    logic [1:0] phase_reg, phase_next;
    vertex_t    v0_reg, v1_reg;
    logic       accept;

    assign s_ready = (phase_reg != PH_THIRD) || !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (phase_reg == PH_THIRD);

    always_comb begin
        q_data.e1x = sdiff(v1_reg.pos_x, v0_reg.pos_x);
        q_data.e1y = sdiff(v1_reg.pos_y, v0_reg.pos_y);
        q_data.e1z = sdiff(v1_reg.pos_z, v0_reg.pos_z);
        q_data.e2x = sdiff(s_vertex.pos_x, v0_reg.pos_x);
        q_data.e2y = sdiff(s_vertex.pos_y, v0_reg.pos_y);
        q_data.e2z = sdiff(s_vertex.pos_z, v0_reg.pos_z);
        q_data.du1 = sdiff(v1_reg.tex_u, v0_reg.tex_u);
        q_data.dv1 = sdiff(v1_reg.tex_v, v0_reg.tex_v);
        q_data.du2 = sdiff(s_vertex.tex_u, v0_reg.tex_u);
        q_data.dv2 = sdiff(s_vertex.tex_v, v0_reg.tex_v);
    end

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_SECOND: phase_next = PH_THIRD;
                PH_THIRD:  phase_next = PH_FIRST;
                default:   phase_next = PH_SECOND;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= '0;
            v1_reg <= '0;
        end else if (accept) begin
            if (phase_reg == PH_SECOND) begin
                v1_reg <= s_vertex;
            end else if (phase_reg != PH_THIRD) begin
                v0_reg <= s_vertex;
            end
        end
    end

endmodule

// ===== design/ttv_back.sv =====
// Back end: cross products, sign, normalisation, unit scaling and result words.
`timescale 1ns / 1ps
module ttv_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_pop,
    input  ttv_pkg::tri_t    q_head,
    output logic             m_valid,
    input  logic             m_ready,
    output ttv_pkg::result_t m_result
);
    import ttv_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ABS  = 3'd2;
    localparam logic [2:0] ST_NORM = 3'd3;
    localparam logic [2:0] ST_SQ   = 3'd4;
    localparam logic [2:0] ST_ROOT = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    localparam logic [3:0] TOP_BIT = 4'(MAG_BITS - 1);

    logic [2:0]                state_reg;
    tri_t                      tri_reg;
    logic [3:0]                cnt_reg;
    logic [2:0]                idx_reg;
    logic signed [2*DELTA_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   acc_reg [4];
    logic [ACC_W-1:0]          mag_reg [3];
    logic [2:0]                neg_reg;
    logic                      flip_reg;
    logic [31:0]               s_reg;
    logic [1:0]                ci_reg;
    logic [3:0]                bit_reg;
    logic                      ph_reg;
    logic [MAG_BITS-1:0]       q_reg;
    logic [31:0]               tt_reg;
    logic [2*MAG_BITS-1:0]     csq_reg;
    logic signed [15:0]        res_reg [3];
    logic [1:0]                out_cnt_reg;

    logic signed [DELTA_W-1:0]   op_a, op_b;
    logic signed [2*DELTA_W-1:0] mul;
    logic signed [ACC_W-1:0]     prod_ext;
    logic [ACC_W-1:0]            orv;
    logic [MAG_BITS-1:0]         c_sel, cand, q_fin;
    logic [15:0]                 t_val;
    logic [63:0]                 lhs, rhs;
    logic                        fits;
    logic [15:0]                 q_ext;

    always_comb begin
        unique case (cnt_reg[2:0])
            3'd0:    begin op_a = tri_reg.du1; op_b = tri_reg.dv2; end
            3'd1:    begin op_a = tri_reg.du2; op_b = tri_reg.dv1; end
            3'd2:    begin op_a = tri_reg.dv2; op_b = tri_reg.e1x; end
            3'd3:    begin op_a = tri_reg.dv1; op_b = tri_reg.e2x; end
            3'd4:    begin op_a = tri_reg.dv2; op_b = tri_reg.e1y; end
            3'd5:    begin op_a = tri_reg.dv1; op_b = tri_reg.e2y; end
            3'd6:    begin op_a = tri_reg.dv2; op_b = tri_reg.e1z; end
            default: begin op_a = tri_reg.dv1; op_b = tri_reg.e2z; end
        endcase
    end

    assign mul      = op_a * op_b;
    assign prod_ext = {prod_reg[2*DELTA_W-1], prod_reg};
    assign orv      = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign c_sel    = mag_reg[ci_reg][MAG_BITS-1:0];
    assign cand     = q_reg | (MAG_BITS'(1) << bit_reg);
    assign t_val    = {cand, 1'b0} - 16'd1;
    assign lhs      = {32'd0, tt_reg} * {32'd0, s_reg};
    assign rhs      = {4'd0, csq_reg, 30'd0};
    assign fits     = (lhs <= rhs);
    assign q_fin    = fits ? cand : q_reg;
    assign q_ext    = {1'b0, q_fin};

    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign m_valid = (state_reg == ST_EMIT);

    always_comb begin
        m_result.tangent_x        = res_reg[0];
        m_result.tangent_y        = res_reg[1];
        m_result.tangent_z        = res_reg[2];
        m_result.last_of_triangle = (out_cnt_reg == 2'd2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            out_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_MUL;
                        cnt_reg   <= '0;
                    end
                end
                ST_MUL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'd8) begin
                        state_reg <= ST_ABS;
                    end
                end
                ST_ABS: state_reg <= ST_NORM;
                ST_NORM: begin
                    cnt_reg <= '0;
                    if (orv == '0) begin
                        state_reg <= ST_EMIT;
                    end else if ((orv >> MAG_BITS) == '0 && orv[MAG_BITS-1]) begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'd2) begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (ph_reg && bit_reg == '0 && ci_reg == 2'd2) begin
                        state_reg   <= ST_EMIT;
                        out_cnt_reg <= '0;
                    end
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        out_cnt_reg <= out_cnt_reg + 1'b1;
                        if (out_cnt_reg == 2'd2) begin
                            state_reg   <= ST_IDLE;
                            out_cnt_reg <= '0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                tri_reg <= q_head;
                for (int i = 0; i < 4; i++) begin
                    acc_reg[i] <= '0;
                end
            end
            ST_MUL: begin
                prod_reg <= mul;
                idx_reg  <= cnt_reg[2:0];
                if (cnt_reg != '0) begin
                    if (idx_reg[0]) begin
                        acc_reg[idx_reg[2:1]] <= acc_reg[idx_reg[2:1]] - prod_ext;
                    end else begin
                        acc_reg[idx_reg[2:1]] <= acc_reg[idx_reg[2:1]] + prod_ext;
                    end
                end
            end
            ST_ABS: begin
                flip_reg <= acc_reg[0][ACC_W-1];
                for (int i = 0; i < 3; i++) begin
                    neg_reg[i] <= acc_reg[i+1][ACC_W-1];
                    mag_reg[i] <= acc_reg[i+1][ACC_W-1] ? -acc_reg[i+1] : acc_reg[i+1];
                end
            end
            ST_NORM: begin
                s_reg   <= '0;
                ci_reg  <= '0;
                bit_reg <= TOP_BIT;
                ph_reg  <= 1'b0;
                q_reg   <= '0;
                if (orv == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        res_reg[i] <= '0;
                    end
                end else if ((orv >> MAG_BITS) != '0) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end else if (!orv[MAG_BITS-1]) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            ST_SQ: begin
                s_reg <= s_reg + mag_reg[cnt_reg[1:0]][MAG_BITS-1:0]
                               * mag_reg[cnt_reg[1:0]][MAG_BITS-1:0];
            end
            ST_ROOT: begin
                ph_reg <= !ph_reg;
                if (!ph_reg) begin
                    tt_reg  <= t_val * t_val;
                    csq_reg <= c_sel * c_sel;
                end else if (bit_reg != '0) begin
                    q_reg   <= q_fin;
                    bit_reg <= bit_reg - 1'b1;
                end else begin
                    res_reg[ci_reg] <= ((neg_reg[ci_reg] != flip_reg) && q_fin != '0)
                                       ? -q_ext : q_ext;
                    q_reg   <= '0;
                    bit_reg <= TOP_BIT;
                    ci_reg  <= ci_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/triangle_tangent_vector_top.sv =====
// Top level of the triangle tangent vector block.
`timescale 1ns / 1ps
// Usage:
//   s_ channel: one vertex word per handshake (position and uv, Q16.16),
//   three words per triangle. The first two are held; the third completes
//   the triangle, which is queued (two deep) for the back end.
//   m_ channel: three result words per triangle, each the Q2.14 unit
//   tangent, with last_of_triangle set on the third.
//   Throughput: the front end takes a vertex each cycle while the queue has
//   room. The back end works one triangle at a time, its cross products on
//   one shared 33x33 multiplier: it takes the triangle, forms the products,
//   the magnitudes, one-bit normalising shifts, the squares and the bitwise
//   unit scaling, then sends 3 result words. A zero tangent skips the
//   shifts, the squares and the scaling.
//   Reset (aresetn low, synchronous) clears held vertices, vertex phase,
//   queue and back-end state.
//   A stalled receiver holds the current result word; the back end waits
//   and the front end keeps accepting until a third vertex meets a full queue.
module triangle_tangent_vector_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ttv_pkg::vertex_t s_vertex,
    output logic             m_valid,
    input  logic             m_ready,
    output ttv_pkg::result_t m_result
);
    import ttv_pkg::*;

    tri_t q_in, q_head;
    logic q_push, q_full, q_pop, q_valid;

    ttv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_vertex (s_vertex),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    ttv_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    ttv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_head   (q_head),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

endmodule
